// ===== design/keyboard_scancode_decoder_fifo_core_defines.svh =====
// Assertion macros used by the keyboard scancode decoder back end.
// Expects clk and arst_n in the scope of each use.
`ifndef KEYBOARD_SCANCODE_DECODER_FIFO_CORE_DEFINES_SVH
`define KEYBOARD_SCANCODE_DECODER_FIFO_CORE_DEFINES_SVH

// Same-cycle implication.
`define KSCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KSCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/kscd_pkg.sv =====
// Shared types, scancode constants and ring helpers of the scancode decoder.
// No dependencies.
`default_nettype none
package kscd_pkg;

	localparam int RING_DEPTH = 256;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int TBL_DEPTH  = 768;
	localparam int TBL_AW     = $clog2(TBL_DEPTH);
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	typedef logic [RING_AW-1:0] ring_ptr_t;

	typedef enum logic [1:0] {
		OP_KEY    = 2'd0,
		OP_READ   = 2'd1,
		OP_TWRITE = 2'd2
	} op_t;

	localparam logic [1:0] LAYER_PLAIN = 2'd0;
	localparam logic [1:0] LAYER_SHIFT = 2'd1;
	localparam logic [1:0] LAYER_CAPS  = 2'd2;
	localparam logic [1:0] LAYER_NONE  = 2'd3;

	localparam logic [7:0] SC_PREFIX     = 8'hE0;
	localparam logic [7:0] SC_CAPS       = 8'h3A;
	localparam logic [7:0] SC_SCROLL     = 8'h46;
	localparam logic [7:0] SC_NUM        = 8'h45;
	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] SC_LCTRL      = 8'h1D;
	localparam logic [7:0] SC_LCTRL_BRK  = 8'h9D;
	localparam logic [7:0] SC_LALT       = 8'h38;
	localparam logic [7:0] SC_LALT_BRK   = 8'hB8;
	localparam logic [7:0] SC_ESCAPE     = 8'h76;
	localparam logic [7:0] KBD_SET_LEDS  = 8'hED;

	localparam logic [2:0] LED_SCROLL = 3'b001;
	localparam logic [2:0] LED_NUM    = 3'b010;
	localparam logic [2:0] LED_CAPS   = 3'b100;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_KBD  = 1'b1;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_PUSH   = 2'd1,
		CMD_TWRITE = 2'd2,
		CMD_LEDS   = 2'd3
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] code;
		logic [1:0] layer;
		logic [7:0] data;
		logic       ctrl;
		logic       alt;
		logic [2:0] leds;
	} cmd_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] rbyte;
		logic       last;
		logic       empty;
		logic       ovf;
		logic       ctrl;
		logic       alt;
		logic [2:0] leds;
	} res_t;

	function automatic ring_ptr_t ring_next(input ring_ptr_t p);
		return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage
`default_nettype wire

// ===== design/kscd_cmdq.sv =====
// Short command queue between the decoder front and the back end.
// Depends on kscd_pkg.
`default_nettype none
module kscd_cmdq import kscd_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	input  cmd_t push_cmd,
	output logic full,
	input  wire  pop,
	output logic not_empty,
	output cmd_t head
);

	cmd_t                 entry_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]   wr_idx_q;
	logic [CMDQ_AW-1:0]   rd_idx_q;
	logic [CMDQ_CW-1:0]   count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full      = (count_q == CMDQ_CW'(CMDQ_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_idx_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_idx_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_idx_q <= (wr_idx_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
			end
			if (do_pop) begin
				rd_idx_q <= (rd_idx_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/kscd_front.sv =====
// Decoder front: accepts input words, tracks prefix, modifiers and lock LEDs,
// and turns each word that needs one into a back-end command. Depends on kscd_pkg.
`default_nettype none
module kscd_front import kscd_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [1:0] opcode,
	input  wire  [7:0] key_byte,
	input  wire  [1:0] table_layer,
	input  wire  [7:0] table_char,
	input  wire        q_full,
	input  wire        clearing,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic       prefix_q, lshift_q, rshift_q, ctrl_q, alt_q;
	logic [2:0] leds_q;
	logic       prefix_n, lshift_n, rshift_n, ctrl_n, alt_n;
	logic [2:0] leds_n;
	logic       fire;

	assign in_ready = !q_full && !clearing;
	assign fire     = in_valid && in_ready;

	always_comb begin
		prefix_n = prefix_q;
		lshift_n = lshift_q;
		rshift_n = rshift_q;
		ctrl_n   = ctrl_q;
		alt_n    = alt_q;
		leds_n   = leds_q;
		q_push   = 1'b0;
		q_cmd.op    = CMD_READ;
		q_cmd.code  = key_byte;
		q_cmd.layer = table_layer;
		q_cmd.data  = table_char;
		if (fire) begin
			unique case (opcode)
				OP_READ: begin
					q_push = 1'b1;
				end
				OP_TWRITE: begin
					q_cmd.op = CMD_TWRITE;
					q_push   = (table_layer != LAYER_NONE);
				end
				OP_KEY: begin
					if (prefix_q) begin
						// consume the byte after the prefix
						prefix_n = 1'b0;
					end else begin
						unique case (key_byte)
							SC_CAPS:       begin leds_n = leds_q ^ LED_CAPS;   q_push = 1'b1; end
							SC_SCROLL:     begin leds_n = leds_q ^ LED_SCROLL; q_push = 1'b1; end
							SC_NUM:        begin leds_n = leds_q ^ LED_NUM;    q_push = 1'b1; end
							SC_LSHIFT:     lshift_n = 1'b1;
							SC_LSHIFT_BRK: lshift_n = 1'b0;
							SC_RSHIFT:     rshift_n = 1'b1;
							SC_RSHIFT_BRK: rshift_n = 1'b0;
							SC_LCTRL:      ctrl_n   = 1'b1;
							SC_LCTRL_BRK:  ctrl_n   = 1'b0;
							SC_LALT:       alt_n    = 1'b1;
							SC_LALT_BRK:   alt_n    = 1'b0;
							SC_ESCAPE:     ;
							SC_PREFIX:     prefix_n = 1'b1;
							default: begin
								q_push = 1'b1;
							end
						endcase
						if (q_push && (leds_n != leds_q)) begin
							q_cmd.op = CMD_LEDS;
						end else begin
							q_cmd.op = CMD_PUSH;
						end
						// pick the table layer from the state before this byte
						if (lshift_q || rshift_q) begin
							q_cmd.layer = LAYER_SHIFT;
						end else if ((leds_q & LED_CAPS) != '0) begin
							q_cmd.layer = LAYER_CAPS;
						end else begin
							q_cmd.layer = LAYER_PLAIN;
						end
					end
				end
				default: ;
			endcase
		end
		q_cmd.ctrl = ctrl_n;
		q_cmd.alt  = alt_n;
		q_cmd.leds = leds_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
			lshift_q <= 1'b0;
			rshift_q <= 1'b0;
			ctrl_q   <= 1'b0;
			alt_q    <= 1'b0;
			leds_q   <= '0;
		end else begin
			prefix_q <= prefix_n;
			lshift_q <= lshift_n;
			rshift_q <= rshift_n;
			ctrl_q   <= ctrl_n;
			alt_q    <= alt_n;
			leds_q   <= leds_n;
		end
	end

endmodule
`default_nettype wire

// ===== design/kscd_back.sv =====
// Decoder back end: key tables, character ring and the output register.
// Depends on kscd_pkg and the assertion macros header.
`default_nettype none
`include "keyboard_scancode_decoder_fifo_core_defines.svh"
module kscd_back import kscd_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   q_not_empty,
	input  cmd_t  q_head,
	output logic  q_pop,
	output logic  clearing,
	output logic  out_valid,
	input  wire   out_ready,
	output res_t  out_res
);

	logic [7:0]        tbl_mem [0:TBL_DEPTH-1];
	logic [7:0]        ring_mem [0:RING_DEPTH-1];

	logic              clr_busy_q;
	logic [TBL_AW-1:0] clr_idx_q;
	logic              valid_s1;
	logic              phase_s1;
	cmd_t              cmd_s1;
	logic [7:0]        tbl_q;
	logic [7:0]        ring_q;
	ring_ptr_t         wr_ptr_q;
	ring_ptr_t         rd_ptr_q;
	logic              dropped_q;
	logic              out_valid_q;
	res_t              res_q;

	logic              out_ok;
	logic              fin_go;
	logic              s1_done;
	logic              out_load;
	logic              ring_we;
	logic              drop_set;
	logic              rd_adv;
	logic              tbl_we;
	logic [TBL_AW-1:0] tbl_waddr;
	logic [7:0]        tbl_wdata;
	logic              ring_empty;
	res_t              res_n;

	assign clearing   = clr_busy_q;
	assign out_valid  = out_valid_q;
	assign out_res    = res_q;
	assign out_ok     = !out_valid_q || out_ready;
	assign q_pop      = q_not_empty && !valid_s1 && !clr_busy_q;
	assign ring_empty = (rd_ptr_q == wr_ptr_q);

	always_comb begin
		fin_go   = 1'b0;
		s1_done  = 1'b1;
		out_load = 1'b0;
		ring_we  = 1'b0;
		drop_set = 1'b0;
		rd_adv   = 1'b0;
		tbl_we   = 1'b0;
		res_n.kind  = KIND_CHAR;
		res_n.rbyte = '0;
		res_n.last  = 1'b1;
		res_n.empty = 1'b0;
		res_n.ovf   = dropped_q;
		res_n.ctrl  = cmd_s1.ctrl;
		res_n.alt   = cmd_s1.alt;
		res_n.leds  = cmd_s1.leds;
		if (valid_s1) begin
			unique case (cmd_s1.op)
				CMD_TWRITE: begin
					fin_go = 1'b1;
					tbl_we = 1'b1;
				end
				CMD_PUSH: begin
					fin_go = 1'b1;
					if (ring_next(wr_ptr_q) != rd_ptr_q) begin
						ring_we = 1'b1;
					end else begin
						drop_set = 1'b1;
					end
				end
				CMD_READ: begin
					fin_go   = out_ok;
					out_load = out_ok;
					if (ring_empty) begin
						res_n.empty = 1'b1;
					end else begin
						res_n.rbyte = ring_q;
						rd_adv      = out_ok;
					end
				end
				CMD_LEDS: begin
					fin_go     = out_ok;
					out_load   = out_ok;
					res_n.kind = KIND_KBD;
					if (phase_s1) begin
						res_n.rbyte = {5'b0, cmd_s1.leds};
					end else begin
						// send the command word first, hold for the LED word
						res_n.rbyte = KBD_SET_LEDS;
						res_n.last  = 1'b0;
						s1_done     = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (clr_busy_q) begin
			tbl_waddr = clr_idx_q;
			tbl_wdata = '0;
		end else begin
			tbl_waddr = {cmd_s1.layer, cmd_s1.code};
			tbl_wdata = cmd_s1.data;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q || tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (q_pop) begin
			tbl_q <= tbl_mem[{q_head.layer, q_head.code}];
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[wr_ptr_q] <= tbl_q;
		end
		if (q_pop) begin
			ring_q <= ring_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_head;
		end
		if (out_load) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_idx_q   <= '0;
			valid_s1    <= 1'b0;
			phase_s1    <= 1'b0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == TBL_AW'(TBL_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (q_pop) begin
				valid_s1 <= 1'b1;
				phase_s1 <= 1'b0;
			end else if (fin_go) begin
				if (s1_done) begin
					valid_s1 <= 1'b0;
				end else begin
					phase_s1 <= 1'b1;
				end
			end
			if (ring_we) begin
				wr_ptr_q <= ring_next(wr_ptr_q);
			end
			if (rd_adv) begin
				rd_ptr_q <= ring_next(rd_ptr_q);
			end
			if (drop_set) begin
				dropped_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`KSCD_ASSERT_NEXT(a_push_keeps_gap, ring_we, wr_ptr_q != rd_ptr_q, "ring push filled last slot")
	`KSCD_ASSERT_NOW(a_idle_while_clearing, clr_busy_q, !valid_s1, "command active during table clear")
	`KSCD_ASSERT_NEXT(a_led_pair, fin_go && (cmd_s1.op == CMD_LEDS) && !phase_s1, valid_s1 && phase_s1 && out_valid_q, "LED word not pending after command word")
	`KSCD_ASSERT_NOW(a_no_read_of_empty, rd_adv, !ring_empty, "pop from empty ring")

endmodule
`default_nettype wire

// ===== design/keyboard_scancode_decoder_fifo_core.sv =====
// Top level of the keyboard scancode decoder with character ring.
// Depends on kscd_pkg, kscd_front, kscd_cmdq and kscd_back.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | s_tuser opcode, s_tdata key/layer/char
//  m_*     | out | m_tvalid/m_tready | m_tuser kind, m_tlast, m_tdata byte+status
//
// The front takes one word per cycle while s_tready is high, into a four-entry command queue.
// The back end handles one command at a time (table or ring read, then
// ring write or result); a lock key gives two results, the command word, then the LED word.
// After reset a sweep over all 768 table entries clears the key tables; s_tready is low.
// A stalled m_tready holds the output register, the queue fills and then
// s_tready drops.
`default_nettype none
module keyboard_scancode_decoder_fifo_core import kscd_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // key_byte[7:0], table_layer[9:8], table_char[17:10], zeros
	input  wire  [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // result_byte[7:0], buffer_empty, overflow_seen,
	                               // ctrl_held, alt_held, led_bits[14:12], zero
	output logic        m_tuser,   // result_kind
	output logic        m_tlast    // last_of_run
);

	logic q_push, q_full, q_pop, q_not_empty, clearing;
	cmd_t q_cmd, q_head;
	res_t res;

	kscd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.opcode      (s_tuser),
		.key_byte    (s_tdata[7:0]),
		.table_layer (s_tdata[9:8]),
		.table_char  (s_tdata[17:10]),
		.q_full      (q_full),
		.clearing    (clearing),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	kscd_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	kscd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.clearing    (clearing),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (res)
	);

	assign m_tdata = {1'b0, res.leds, res.alt, res.ctrl, res.ovf, res.empty, res.rbyte};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule
`default_nettype wire
